[hdl/pbwfs_pkg.sv]
// Shared types and constants for the protobuf wire field scanner.
// Used by protobuf_wire_field_scanner_top; depends on nothing else.
package pbwfs_pkg;

  // Default width of the length-delimited byte counter.
  localparam int unsigned LENGTH_BITS_DEFAULT = 32;

  // A varint may span at most this many bytes.
  localparam int unsigned VARINT_MAX_BYTES = 10;

  // Depth of the result queue; it must hold two results beyond one in flight.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Payload widths.
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned WT_W    = 3;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TDATA_W = 112;

  // Wire type codes.
  localparam logic [WT_W-1:0] WT_VARINT  = 3'd0;
  localparam logic [WT_W-1:0] WT_FIXED64 = 3'd1;
  localparam logic [WT_W-1:0] WT_LEN     = 3'd2;
  localparam logic [WT_W-1:0] WT_FIXED32 = 3'd5;

  typedef enum logic [2:0] {
    PH_KEY     = 3'd0,
    PH_VALUE   = 3'd1,
    PH_SKIP    = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_FIELD     = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_MSG_OK    = 3'd2,
    KIND_BAD_WIRE  = 3'd3,
    KIND_TOO_LONG  = 3'd4,
    KIND_TRUNCATED = 3'd5
  } kind_t;

  // One result request as held in the output queue.
  typedef struct packed {
    kind_t               kind;
    logic [NUM_W-1:0]    field_number;
    logic [WT_W-1:0]     wtype;
    logic [VALUE_W-1:0]  field_value;
    logic [BYTE_W-1:0]   payload_byte;
    logic                last_of_payload;
    logic                last_of_run;
  } result_t;

endpackage

[hdl/protobuf_wire_field_scanner_top.sv]
// Protobuf wire field scanner: byte-serial key/value walker with a result queue.
// Depends on pbwfs_pkg for phase and kind codes and the result record type.
//
// Each result is registered into the result queue when its input byte is accepted.
// Throughput: one input byte per cycle while each byte gives at most one result and
// m_axis does not stall; a byte that gives two results (a field closed by the end of the
// message) queues both in the four-entry result queue, drained by the single-result port.
// Reset (rst, synchronous, active high) clears the decoder state and empties the queue.
module protobuf_wire_field_scanner_top #(
  parameter int unsigned LENGTH_BITS = pbwfs_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // Input requests: one message byte each.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // end_of_message
  // Result requests.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] field_number, [34:32] wire type, [98:35] field_value,
  // [106:99] payload_byte, [107] last_of_payload, [111:108] zero
  output logic [111:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // [2:0] kind
  output logic         m_axis_tlast    // last_of_run
);

  localparam int unsigned AW = pbwfs_pkg::QUEUE_AW;

  // Decoder state.
  pbwfs_pkg::phase_t                  phase, phase_next, phase_step;
  logic [3:0]                         shift_count, shift_count_next, shift_count_step;
  logic [pbwfs_pkg::VALUE_W-1:0]      accumulator, accumulator_next, accumulator_step;
  logic [pbwfs_pkg::NUM_W-1:0]        current_number, current_number_next, current_number_step;
  logic [pbwfs_pkg::WT_W-1:0]         current_wire_type, current_wire_type_next;
  logic [pbwfs_pkg::WT_W-1:0]         current_wire_type_step;
  logic [LENGTH_BITS-1:0]             bytes_remaining, bytes_remaining_next, bytes_remaining_step;
  logic                               error_seen, error_seen_next, error_seen_step;

  // Result queue.
  pbwfs_pkg::result_t                 queue [pbwfs_pkg::QUEUE_DEPTH];
  logic [AW-1:0]                      wr_ptr, rd_ptr;
  logic [AW:0]                        count, count_next;

  logic s_fire, m_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  // Room for the two results that one byte may give.
  assign s_axis_tready = count <= (AW+1)'(pbwfs_pkg::QUEUE_DEPTH - 2);

  // Varint byte step shared by the key, value and length phases.
  logic [6:0]                    shift_amount;
  logic [pbwfs_pkg::VALUE_W-1:0] acc_new;
  logic [3:0]                    shift_inc;
  logic                          varint_overrun, varint_done, varint_error;
  logic [LENGTH_BITS-1:0]        remaining_dec;
  logic                          length_too_wide;

  always_comb begin
    shift_amount   = {3'd0, shift_count} * 7'd7;
    acc_new        = accumulator |
                     ({{(pbwfs_pkg::VALUE_W-7){1'b0}}, s_axis_tdata[6:0]} << shift_amount);
    shift_inc      = shift_count + 4'd1;
    varint_overrun = shift_count > 4'(pbwfs_pkg::VARINT_MAX_BYTES - 1);
    // A completed varint is one whose byte clears the continuation bit.
    varint_done    = !varint_overrun && !s_axis_tdata[7];
    // The tenth byte still continuing means the varint is too long.
    varint_error   = varint_overrun ||
                     (s_axis_tdata[7] && shift_inc >= 4'(pbwfs_pkg::VARINT_MAX_BYTES));
    remaining_dec  = bytes_remaining - LENGTH_BITS'(1);
    length_too_wide = (acc_new >> LENGTH_BITS) != '0;
  end

  // Next state for one accepted byte, before the end-of-message return to reset.
  always_comb begin
    phase_step             = phase;
    shift_count_step       = shift_count;
    accumulator_step       = accumulator;
    current_number_step    = current_number;
    current_wire_type_step = current_wire_type;
    bytes_remaining_step   = bytes_remaining;
    error_seen_step        = error_seen;
    if (!error_seen) begin
      case (phase)
        pbwfs_pkg::PH_KEY: begin
          if (varint_error) begin
            error_seen_step = 1'b1;
          end else if (varint_done) begin
            current_number_step    = acc_new[pbwfs_pkg::NUM_W+2:3];
            current_wire_type_step = acc_new[2:0];
            accumulator_step       = '0;
            shift_count_step       = '0;
            case (acc_new[2:0])
              pbwfs_pkg::WT_VARINT: begin
                phase_step = pbwfs_pkg::PH_VALUE;
              end
              pbwfs_pkg::WT_FIXED64: begin
                bytes_remaining_step = LENGTH_BITS'(8);
                phase_step           = pbwfs_pkg::PH_SKIP;
              end
              pbwfs_pkg::WT_FIXED32: begin
                bytes_remaining_step = LENGTH_BITS'(4);
                phase_step           = pbwfs_pkg::PH_SKIP;
              end
              pbwfs_pkg::WT_LEN: begin
                phase_step = pbwfs_pkg::PH_LENGTH;
              end
              default: begin
                error_seen_step = 1'b1;
              end
            endcase
          end else begin
            accumulator_step = acc_new;
            shift_count_step = shift_inc;
          end
        end
        pbwfs_pkg::PH_VALUE, pbwfs_pkg::PH_LENGTH: begin
          if (varint_error) begin
            error_seen_step = 1'b1;
          end else if (varint_done) begin
            accumulator_step = '0;
            shift_count_step = '0;
            if (phase == pbwfs_pkg::PH_VALUE) begin
              phase_step = pbwfs_pkg::PH_KEY;
            end else if (length_too_wide) begin
              error_seen_step = 1'b1;
            end else begin
              bytes_remaining_step = acc_new[LENGTH_BITS-1:0];
              phase_step = (acc_new != '0) ? pbwfs_pkg::PH_PAYLOAD : pbwfs_pkg::PH_KEY;
            end
          end else begin
            accumulator_step = acc_new;
            shift_count_step = shift_inc;
          end
        end
        pbwfs_pkg::PH_SKIP, pbwfs_pkg::PH_PAYLOAD: begin
          bytes_remaining_step = remaining_dec;
          if (remaining_dec == '0) begin
            phase_step = pbwfs_pkg::PH_KEY;
          end
        end
        default: begin
          phase_step = pbwfs_pkg::PH_KEY;
        end
      endcase
    end
  end

  // The end of a message returns every decoder state register to its reset value.
  always_comb begin
    phase_next             = phase_step;
    shift_count_next       = shift_count_step;
    accumulator_next       = accumulator_step;
    current_number_next    = current_number_step;
    current_wire_type_next = current_wire_type_step;
    bytes_remaining_next   = bytes_remaining_step;
    error_seen_next        = error_seen_step;
    if (s_axis_tlast) begin
      phase_next             = pbwfs_pkg::PH_KEY;
      shift_count_next       = '0;
      accumulator_next       = '0;
      current_number_next    = '0;
      current_wire_type_next = '0;
      bytes_remaining_next   = '0;
      error_seen_next        = 1'b0;
    end
  end

  // Results of one byte: at most one from the field walk, one from the message end.
  pbwfs_pkg::result_t first_res, end_res, slot_a, slot_b;
  logic               first_valid, end_valid;
  logic [1:0]         push_count;

  always_comb begin
    first_res   = '0;
    first_valid = 1'b0;
    if (!error_seen) begin
      case (phase)
        pbwfs_pkg::PH_KEY: begin
          if (varint_error) begin
            first_valid    = 1'b1;
            first_res.kind = pbwfs_pkg::KIND_TOO_LONG;
          end else if (varint_done && acc_new[2:0] != pbwfs_pkg::WT_VARINT &&
                       acc_new[2:0] != pbwfs_pkg::WT_FIXED64 &&
                       acc_new[2:0] != pbwfs_pkg::WT_FIXED32 &&
                       acc_new[2:0] != pbwfs_pkg::WT_LEN) begin
            first_valid            = 1'b1;
            first_res.kind         = pbwfs_pkg::KIND_BAD_WIRE;
            first_res.field_number = acc_new[pbwfs_pkg::NUM_W+2:3];
            first_res.wtype        = acc_new[2:0];
          end
        end
        pbwfs_pkg::PH_VALUE, pbwfs_pkg::PH_LENGTH: begin
          if (varint_error) begin
            first_valid    = 1'b1;
            first_res.kind = pbwfs_pkg::KIND_TOO_LONG;
          end else if (varint_done) begin
            first_valid = 1'b1;
            if (phase == pbwfs_pkg::PH_LENGTH && length_too_wide) begin
              first_res.kind = pbwfs_pkg::KIND_TRUNCATED;
            end else begin
              first_res.kind         = pbwfs_pkg::KIND_FIELD;
              first_res.field_number = current_number;
              first_res.wtype        = (phase == pbwfs_pkg::PH_LENGTH) ?
                                       pbwfs_pkg::WT_LEN : pbwfs_pkg::WT_VARINT;
              first_res.field_value  = acc_new;
            end
          end
        end
        pbwfs_pkg::PH_SKIP: begin
          if (remaining_dec == '0) begin
            first_valid            = 1'b1;
            first_res.kind         = pbwfs_pkg::KIND_FIELD;
            first_res.field_number = current_number;
            first_res.wtype        = current_wire_type;
          end
        end
        pbwfs_pkg::PH_PAYLOAD: begin
          first_valid               = 1'b1;
          first_res.kind            = pbwfs_pkg::KIND_PAYLOAD;
          first_res.field_number    = current_number;
          first_res.wtype           = pbwfs_pkg::WT_LEN;
          first_res.payload_byte    = s_axis_tdata;
          first_res.last_of_payload = remaining_dec == '0;
        end
        default: begin
          first_valid = 1'b0;
        end
      endcase
    end

    // Closing result: ok only when the message ends cleanly between fields.
    end_res   = '0;
    end_valid = s_axis_tlast && !error_seen_step;
    end_res.kind = (phase_step == pbwfs_pkg::PH_KEY && shift_count_step == '0) ?
                   pbwfs_pkg::KIND_MSG_OK : pbwfs_pkg::KIND_TRUNCATED;
    end_res.last_of_run   = 1'b1;
    first_res.last_of_run = !end_valid;

    slot_a     = first_valid ? first_res : end_res;
    slot_b     = end_res;
    push_count = {1'b0, first_valid} + {1'b0, end_valid};
  end

  assign count_next = count + {{(AW-1){1'b0}}, s_fire ? push_count : 2'd0}
                            - {{AW{1'b0}}, m_fire};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= pbwfs_pkg::PH_KEY;
      shift_count       <= '0;
      accumulator       <= '0;
      current_number    <= '0;
      current_wire_type <= '0;
      bytes_remaining   <= '0;
      error_seen        <= 1'b0;
      wr_ptr            <= '0;
      rd_ptr            <= '0;
      count             <= '0;
    end else begin
      if (s_fire) begin
        phase             <= phase_next;
        shift_count       <= shift_count_next;
        accumulator       <= accumulator_next;
        current_number    <= current_number_next;
        current_wire_type <= current_wire_type_next;
        bytes_remaining   <= bytes_remaining_next;
        error_seen        <= error_seen_next;
        wr_ptr            <= wr_ptr + AW'(push_count);
      end
      if (m_fire) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count_next;
    end
  end

  // Queue storage needs no reset; entries are only read once counted in.
  always_ff @(posedge clk) begin
    if (s_fire && push_count != 2'd0) begin
      queue[wr_ptr] <= slot_a;
    end
    if (s_fire && push_count == 2'd2) begin
      queue[wr_ptr + AW'(1)] <= slot_b;
    end
  end

  pbwfs_pkg::result_t head;
  assign head          = queue[rd_ptr];
  assign m_axis_tvalid = count != '0;
  assign m_axis_tdata  = {4'd0, head.last_of_payload, head.payload_byte, head.field_value,
                          head.wtype, head.field_number};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last_of_run;

  // The queue never holds more entries than it has.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(pbwfs_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  // A byte that ends the message leaves the decoder back at its reset state.
  a_eom_resets: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_axis_tlast |=>
      phase == pbwfs_pkg::PH_KEY && shift_count == '0 && !error_seen)
    else $error("decoder not returned to reset after end of message");

  // Once an error is flagged the walk stands still until the message ends.
  a_error_freezes: assert property (@(posedge clk) disable iff (rst)
    error_seen && !(s_fire && s_axis_tlast) |=> $stable(phase) && $stable(bytes_remaining))
    else $error("decoder moved after an error");

  // Every accepted payload byte leaves a result waiting.
  a_payload_result: assert property (@(posedge clk) disable iff (rst)
    s_fire && !error_seen && phase == pbwfs_pkg::PH_PAYLOAD |=> count != '0)
    else $error("payload byte gave no result");

endmodule
